// ===== hdl/assert_macros.svh =====
// Assertion macros used by the frame parser top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define IMUFP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed: %m");
`define IMUFP_ASSERT_NEVER(lbl, expr) \
  `IMUFP_ASSERT(lbl, !(expr))
`else
`define IMUFP_ASSERT(lbl, prop)
`define IMUFP_ASSERT_NEVER(lbl, expr)
`endif
`endif

// ===== hdl/imufp_pkg.sv =====
// Types and constants shared by the frame parser and yaw integrator.
package imufp_pkg;

  localparam int CNT_W    = 10;
  localparam int THR_W    = 24;
  localparam int CORR_W   = 26;
  localparam int BSUM_W   = 26;
  localparam int CORR_MAX = 33554431;
  localparam int CORR_MIN = -33554432;

  localparam logic [7:0] SYNC_BYTE  = 8'h55;
  localparam logic [7:0] TYPE_ACC   = 8'h51;
  localparam logic [7:0] TYPE_RATE  = 8'h52;
  localparam logic [7:0] TYPE_ANGLE = 8'h53;

  localparam logic [1:0] KIND_ACC   = 2'd0;
  localparam logic [1:0] KIND_RATE  = 2'd1;
  localparam logic [1:0] KIND_ANGLE = 2'd2;

  localparam logic [1:0] REG_WARMUP = 2'd0;
  localparam logic [1:0] REG_BIAS   = 2'd1;
  localparam logic [1:0] REG_STILL  = 2'd2;
  localparam logic [1:0] REG_THRESH = 2'd3;

  typedef enum logic [1:0] {
    DivRateBias,
    DivDeltaBias,
    DivRateOff,
    DivDeltaOff
  } div_sel_e;

  typedef struct packed {
    logic [CNT_W-1:0] warmup;
    logic [CNT_W-1:0] bias;
    logic [CNT_W-1:0] still;
    logic [THR_W-1:0] thresh;
  } cfg_t;

  typedef struct packed {
    logic     step;
    logic     div_start;
    div_sel_e div_sel;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic pend;
    logic pend_angle;
    logic bias_end;
    logic still_end;
    logic div_done;
    logic div_busy;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/imufp_div.sv =====
// Restoring divider, one quotient bit per cycle, truncating toward zero.
module imufp_div #(
  parameter int DVW = 37
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [DVW-1:0]         dividend_i,
  input  logic [imufp_pkg::CNT_W-1:0]   divisor_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic signed [DVW-1:0]         quot_o
);

  localparam int CntW = $clog2(DVW + 1);
  localparam int DW   = imufp_pkg::CNT_W;

  logic            run_q, done_q, neg_q;
  logic [DVW-1:0]  mag_q;
  logic [DW-1:0]   rem_q;
  logic [CntW-1:0] cnt_q;
  logic [DW:0]     rem_sh, rem_nx;
  logic            fits;

  assign rem_sh = {rem_q, mag_q[DVW-1]};
  assign fits   = rem_sh >= {1'b0, divisor_i};
  assign rem_nx = fits ? rem_sh - {1'b0, divisor_i} : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      mag_q  <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        neg_q <= dividend_i[DVW-1];
        mag_q <= dividend_i[DVW-1] ? DVW'(-dividend_i) : DVW'(dividend_i);
        rem_q <= '0;
        cnt_q <= CntW'(DVW);
        run_q <= 1'b1;
      end else if (run_q) begin
        mag_q <= {mag_q[DVW-2:0], fits};
        rem_q <= rem_nx[DW-1:0];
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign busy_o = run_q;
  assign done_o = done_q;
  assign quot_o = neg_q ? -signed'(mag_q) : signed'(mag_q);

endmodule

// ===== hdl/imufp_datapath.sv =====
// Byte parser, yaw calibration and integration registers, result register.
module imufp_datapath #(
  parameter int FB = 8,
  parameter int YW = 40
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  imufp_pkg::cfg_t                   cfg_i,
  input  imufp_pkg::cmd_t                   cmd_i,
  output imufp_pkg::sts_t                   sts_o,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [7:0]                        rx_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        frame_kind_o,
  output logic signed [15:0]                value_x_o,
  output logic signed [15:0]                value_y_o,
  output logic signed [15:0]                value_z_o,
  output logic signed [15:0]                value_w_o,
  output logic signed [imufp_pkg::CORR_W-1:0] corrected_rate_o,
  output logic signed [YW-1:0]              yaw_total_o,
  output logic                              yaw_ready_o
);

  localparam int BW  = FB + 18;
  localparam int SW  = FB + 28;
  localparam int DVW = FB + 29;
  localparam int CW  = (BW + 1 > imufp_pkg::CORR_W + 1) ? BW + 1 : imufp_pkg::CORR_W + 1;
  localparam int XW  = (YW > BW + 1) ? YW : BW + 1;
  localparam int NW  = imufp_pkg::CNT_W;
  localparam int RW  = imufp_pkg::CORR_W;
  localparam int BSW = imufp_pkg::BSUM_W;

  typedef enum logic [1:0] {PhIdle, PhHead, PhBody} phase_e;
  typedef enum logic [1:0] {StWarm, StBias, StRun} stage_e;

  // parser
  phase_e      phase_q;
  logic [3:0]  pos_q;
  logic [7:0]  sum_q;
  logic        pend_q;
  logic [7:0]  store_q [1:9];
  logic        acc;

  // yaw chain
  logic signed [15:0]  prev_q, rate_q;
  stage_e              stage_q;
  logic [NW-1:0]       stage_cnt_q, still_cnt_q, div_n_q;
  logic signed [BSW-1:0] brs_q, bds_q;
  logic signed [SW-1:0]  srs_q, sds_q;
  logic signed [BW-1:0]  rbias_q, dbias_q, roff_q, doff_q;
  logic [YW-1:0]       yaw_q;
  logic                bias_end_q, still_end_q;
  logic signed [RW-1:0] corr_q;

  // output register
  logic                 out_valid_q;
  logic [1:0]           kind_q;
  logic signed [15:0]   ox_q, oy_q, oz_q, ow_q;
  logic signed [RW-1:0] ocorr_q;
  logic [YW-1:0]        oyaw_q;
  logic                 ordy_q;

  // step arithmetic
  logic signed [15:0]   z_w;
  logic signed [17:0]   dd;
  logic signed [16:0]   dw;
  logic signed [BW-1:0] rate_nb, delta_nb;
  logic signed [CW-1:0] cx;
  logic signed [RW-1:0] corr_sat;
  logic [RW-1:0]        mag;
  logic                 is_still;
  logic signed [XW-1:0] inc;
  logic [NW-1:0]        stage_n, still_n;
  logic [1:0]           kind_w;

  // divider
  logic signed [DVW-1:0] dividend, quot;
  logic                  div_done, div_busy;

  assign acc    = in_valid_i && in_ready_o;
  assign z_w    = signed'({store_q[7], store_q[6]});
  assign kind_w = store_q[1][1:0] - 2'd1;

  assign dd = 18'(z_w) - 18'(prev_q);
  always_comb begin
    if (dd > 18'sd32768) begin
      dw = 17'(dd - 18'sd65536);
    end else if (dd < -18'sd32768) begin
      dw = 17'(dd + 18'sd65536);
    end else begin
      dw = 17'(dd);
    end
  end

  assign rate_nb  = (BW'(rate_q) <<< FB) - rbias_q;
  assign delta_nb = (BW'(dw) <<< FB) - dbias_q;
  assign cx       = CW'(rate_nb) - CW'(roff_q);

  always_comb begin
    if (cx > CW'(imufp_pkg::CORR_MAX)) begin
      corr_sat = RW'(imufp_pkg::CORR_MAX);
    end else if (cx < CW'(imufp_pkg::CORR_MIN)) begin
      corr_sat = RW'(imufp_pkg::CORR_MIN);
    end else begin
      corr_sat = RW'(cx);
    end
  end

  assign mag      = corr_sat[RW-1] ? RW'(-corr_sat) : RW'(corr_sat);
  assign is_still = mag < RW'(cfg_i.thresh);
  assign inc      = XW'(delta_nb) - XW'(doff_q);
  assign stage_n  = stage_cnt_q + NW'(1);
  assign still_n  = still_cnt_q + NW'(1);

  always_comb begin
    case (cmd_i.div_sel)
      imufp_pkg::DivRateBias:  dividend = DVW'(brs_q) <<< FB;
      imufp_pkg::DivDeltaBias: dividend = DVW'(bds_q) <<< FB;
      imufp_pkg::DivRateOff:   dividend = DVW'(srs_q);
      default:                 dividend = DVW'(sds_q);
    endcase
  end

  imufp_div #(.DVW(DVW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (div_n_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // parser control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      pos_q   <= '0;
      sum_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      if (cmd_i.emit) begin
        pend_q <= 1'b0;
      end
      if (acc) begin
        unique case (phase_q)
          PhIdle: begin
            if (rx_byte_i == imufp_pkg::SYNC_BYTE) phase_q <= PhHead;
          end
          PhHead: begin
            if (rx_byte_i >= imufp_pkg::TYPE_ACC && rx_byte_i <= imufp_pkg::TYPE_ANGLE) begin
              sum_q   <= imufp_pkg::SYNC_BYTE + rx_byte_i;
              pos_q   <= 4'd2;
              phase_q <= PhBody;
            end else if (rx_byte_i != imufp_pkg::SYNC_BYTE) begin
              phase_q <= PhIdle;
            end
          end
          PhBody: begin
            if (pos_q < 4'd2 || pos_q > 4'd10) begin
              phase_q <= PhIdle;
              pos_q   <= '0;
            end else if (pos_q < 4'd10) begin
              sum_q <= sum_q + rx_byte_i;
              pos_q <= pos_q + 4'd1;
            end else begin
              phase_q <= PhIdle;
              pos_q   <= '0;
              if (rx_byte_i == sum_q) pend_q <= 1'b1;
            end
          end
          default: phase_q <= PhIdle;
        endcase
      end
    end
  end

  // frame bytes
  always_ff @(posedge clk_i) begin
    if (acc && phase_q == PhHead) begin
      store_q[1] <= rx_byte_i;
    end
    if (acc && phase_q == PhBody && pos_q >= 4'd2 && pos_q <= 4'd9) begin
      store_q[pos_q] <= rx_byte_i;
    end
  end

  // yaw chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      rate_q      <= '0;
      stage_q     <= StWarm;
      stage_cnt_q <= '0;
      still_cnt_q <= '0;
      div_n_q     <= '0;
      brs_q       <= '0;
      bds_q       <= '0;
      srs_q       <= '0;
      sds_q       <= '0;
      rbias_q     <= '0;
      dbias_q     <= '0;
      roff_q      <= '0;
      doff_q      <= '0;
      yaw_q       <= '0;
      bias_end_q  <= 1'b0;
      still_end_q <= 1'b0;
      corr_q      <= '0;
    end else if (cmd_i.emit) begin
      if (kind_w == imufp_pkg::KIND_RATE) rate_q <= z_w;
    end else if (cmd_i.step) begin
      prev_q      <= z_w;
      bias_end_q  <= 1'b0;
      still_end_q <= 1'b0;
      corr_q      <= '0;
      unique case (stage_q)
        StWarm: begin
          if (stage_n >= cfg_i.warmup) begin
            stage_q     <= StBias;
            stage_cnt_q <= '0;
          end else begin
            stage_cnt_q <= stage_n;
          end
        end
        StBias: begin
          brs_q <= brs_q + BSW'(rate_q);
          bds_q <= bds_q + BSW'(dw);
          if (stage_n >= cfg_i.bias) begin
            // keep the sums until both divisions have read them
            bias_end_q  <= 1'b1;
            div_n_q     <= stage_n;
            stage_cnt_q <= '0;
            stage_q     <= StRun;
          end else begin
            stage_cnt_q <= stage_n;
          end
        end
        default: begin
          corr_q <= corr_sat;
          yaw_q  <= yaw_q + inc[YW-1:0];
          if (is_still) begin
            srs_q <= srs_q + SW'(rate_nb);
            sds_q <= sds_q + SW'(delta_nb);
            if (still_n >= cfg_i.still) begin
              still_end_q <= 1'b1;
              div_n_q     <= still_n;
              still_cnt_q <= '0;
            end else begin
              still_cnt_q <= still_n;
            end
          end else begin
            still_cnt_q <= '0;
            srs_q       <= '0;
            sds_q       <= '0;
          end
        end
      endcase
    end else if (div_done) begin
      case (cmd_i.div_sel)
        imufp_pkg::DivRateBias: rbias_q <= quot[BW-1:0];
        imufp_pkg::DivDeltaBias: begin
          dbias_q <= quot[BW-1:0];
          brs_q   <= '0;
          bds_q   <= '0;
        end
        imufp_pkg::DivRateOff: roff_q <= quot[BW-1:0];
        default: begin
          doff_q <= quot[BW-1:0];
          srs_q  <= '0;
          sds_q  <= '0;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kind_q  <= kind_w;
      ox_q    <= signed'({store_q[3], store_q[2]});
      oy_q    <= signed'({store_q[5], store_q[4]});
      oz_q    <= z_w;
      ow_q    <= (kind_w == imufp_pkg::KIND_ACC) ? signed'({store_q[9], store_q[8]}) : '0;
      ocorr_q <= (kind_w == imufp_pkg::KIND_ANGLE) ? corr_q : '0;
      oyaw_q  <= yaw_q;
      ordy_q  <= stage_q == StRun;
    end
  end

  assign in_ready_o       = !pend_q;
  assign out_valid_o      = out_valid_q;
  assign frame_kind_o     = kind_q;
  assign value_x_o        = ox_q;
  assign value_y_o        = oy_q;
  assign value_z_o        = oz_q;
  assign value_w_o        = ow_q;
  assign corrected_rate_o = ocorr_q;
  assign yaw_total_o      = signed'(oyaw_q);
  assign yaw_ready_o      = ordy_q;

  assign sts_o.pend       = pend_q;
  assign sts_o.pend_angle = store_q[1] == imufp_pkg::TYPE_ANGLE;
  assign sts_o.bias_end   = bias_end_q;
  assign sts_o.still_end  = still_end_q;
  assign sts_o.div_done   = div_done;
  assign sts_o.div_busy   = div_busy;
  assign sts_o.out_free   = !out_valid_q;

endmodule

// ===== hdl/imufp_ctrl.sv =====
// Sequencer for frame completion: yaw step, divisions and result hand-off.
module imufp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  imufp_pkg::sts_t sts_i,
  output imufp_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {SIdle, SStep, SCheck, SDiv, SEmit} state_e;

  state_e          state_q;
  imufp_pkg::cmd_t cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cmd_q   <= '{step: 1'b0, div_start: 1'b0, div_sel: imufp_pkg::DivRateBias, emit: 1'b0};
    end else begin
      cmd_q.step      <= 1'b0;
      cmd_q.div_start <= 1'b0;
      cmd_q.emit      <= 1'b0;
      unique case (state_q)
        SIdle: begin
          if (sts_i.pend && sts_i.out_free) begin
            if (sts_i.pend_angle) begin
              cmd_q.step <= 1'b1;
              state_q    <= SStep;
            end else begin
              cmd_q.emit <= 1'b1;
              state_q    <= SEmit;
            end
          end
        end
        SStep: state_q <= SCheck;
        SCheck: begin
          if (sts_i.bias_end) begin
            cmd_q.div_sel   <= imufp_pkg::DivRateBias;
            cmd_q.div_start <= 1'b1;
            state_q         <= SDiv;
          end else if (sts_i.still_end) begin
            cmd_q.div_sel   <= imufp_pkg::DivRateOff;
            cmd_q.div_start <= 1'b1;
            state_q         <= SDiv;
          end else begin
            cmd_q.emit <= 1'b1;
            state_q    <= SEmit;
          end
        end
        SDiv: begin
          if (sts_i.div_done) begin
            unique case (cmd_q.div_sel)
              imufp_pkg::DivRateBias: begin
                cmd_q.div_sel   <= imufp_pkg::DivDeltaBias;
                cmd_q.div_start <= 1'b1;
              end
              imufp_pkg::DivRateOff: begin
                cmd_q.div_sel   <= imufp_pkg::DivDeltaOff;
                cmd_q.div_start <= 1'b1;
              end
              default: begin
                cmd_q.emit <= 1'b1;
                state_q    <= SEmit;
              end
            endcase
          end
        end
        SEmit: state_q <= SIdle;
        default: state_q <= SIdle;
      endcase
    end
  end

  assign cmd_o = cmd_q;

endmodule

// ===== hdl/imu_frame_parser_yaw_integrator.sv =====
// A byte is taken whenever in_valid_i and in_ready_o are both high; a frame result is offered
// after its checksum byte once the sequencer issues an emit into a free result register. An angle
// frame first passes the step and check states, and one that closes a bias or still window also
// waits for two serial divisions. Bytes are refused from a good checksum until its result is
// loaded into the result register. Reset is asynchronous and active low; control registers return
// to their defaults at once, with no clearing pass, while frame and result data are not reset.
`include "assert_macros.svh"

module imu_frame_parser_yaw_integrator #(
  parameter int FRACTION_BITS = 8,
  parameter int YAW_WIDTH     = 40
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [3:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [7:0]                          rx_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          frame_kind_o,
  output logic signed [15:0]                  value_x_o,
  output logic signed [15:0]                  value_y_o,
  output logic signed [15:0]                  value_z_o,
  output logic signed [15:0]                  value_w_o,
  output logic signed [imufp_pkg::CORR_W-1:0] corrected_rate_o,
  output logic signed [YAW_WIDTH-1:0]         yaw_total_o,
  output logic                                yaw_ready_o
);

  localparam int NW = imufp_pkg::CNT_W;
  localparam int TW = imufp_pkg::THR_W;

  imufp_pkg::cfg_t cfg_q;
  imufp_pkg::cmd_t cmd;
  imufp_pkg::sts_t sts;
  logic            wr;

  assign wr     = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.warmup <= NW'(100);
      cfg_q.bias   <= NW'(200);
      cfg_q.still  <= NW'(400);
      cfg_q.thresh <= TW'(3355);
    end else if (wr) begin
      unique case (paddr[3:2])
        imufp_pkg::REG_WARMUP: cfg_q.warmup <= pwdata[NW-1:0];
        imufp_pkg::REG_BIAS:   cfg_q.bias   <= pwdata[NW-1:0];
        imufp_pkg::REG_STILL:  cfg_q.still  <= pwdata[NW-1:0];
        imufp_pkg::REG_THRESH: cfg_q.thresh <= pwdata[TW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      imufp_pkg::REG_WARMUP: prdata = 32'(cfg_q.warmup);
      imufp_pkg::REG_BIAS:   prdata = 32'(cfg_q.bias);
      imufp_pkg::REG_STILL:  prdata = 32'(cfg_q.still);
      imufp_pkg::REG_THRESH: prdata = 32'(cfg_q.thresh);
      default:               prdata = '0;
    endcase
  end

  imufp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  imufp_datapath #(.FB(FRACTION_BITS), .YW(YAW_WIDTH)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .frame_kind_o     (frame_kind_o),
    .value_x_o        (value_x_o),
    .value_y_o        (value_y_o),
    .value_z_o        (value_z_o),
    .value_w_o        (value_w_o),
    .corrected_rate_o (corrected_rate_o),
    .yaw_total_o      (yaw_total_o),
    .yaw_ready_o      (yaw_ready_o)
  );

  // result slot must be empty when a request is handed over
  `IMUFP_ASSERT(a_emit_into_free_slot, cmd.emit |-> !out_valid_o)
  `IMUFP_ASSERT(a_step_blocks_bytes, cmd.step |-> !in_ready_o)
  `IMUFP_ASSERT_NEVER(a_start_while_busy, cmd.div_start && sts.div_busy)
  `IMUFP_ASSERT_NEVER(a_step_emit_clash, cmd.step && cmd.emit)

endmodule

// ===== bench/yaw_frame_checker.sv =====
// Checker for the frame parser: tracks the byte and result channels and predicts each frame.
`timescale 1ns / 1ps

module yaw_frame_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [3:0]                          paddr,
  input  logic [31:0]                         pwdata,
  input  logic                                pready,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic [7:0]                          rx_byte_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic [1:0]                          frame_kind_i,
  input  logic signed [15:0]                  value_x_i,
  input  logic signed [15:0]                  value_y_i,
  input  logic signed [15:0]                  value_z_i,
  input  logic signed [15:0]                  value_w_i,
  input  logic signed [imufp_pkg::CORR_W-1:0] corrected_rate_i,
  input  logic signed [39:0]                  yaw_total_i,
  input  logic                                yaw_ready_i,
  output int                                  fail_count_o,
  output int                                  pending_o,
  output int                                  checked_o
);

  typedef enum logic [1:0] {PhIdle, PhHead, PhBody} parse_phase_e;
  typedef enum logic [1:0] {StWarm, StBias, StRun} calib_stage_e;

  typedef struct packed {
    logic [1:0]                   kind;
    logic [15:0]                  x;
    logic [15:0]                  y;
    logic [15:0]                  z;
    logic [15:0]                  w;
    logic [imufp_pkg::CORR_W-1:0] corr;
    logic [39:0]                  yaw;
    logic                         ready;
  } frame_result_t;

  frame_result_t expected_frames[$];

  int unsigned  warm_len, bias_len, still_len, still_thr;
  parse_phase_e phase;
  logic [7:0]   frame_buf[11];
  int           pos;
  logic [7:0]   sum8;
  int           prev_heading, rate_latch;
  calib_stage_e stage;
  int unsigned  stage_cnt, still_cnt;
  longint       bias_rate_acc, bias_delta_acc, rate_bias, delta_bias;
  longint       still_rate_acc, still_delta_acc, rate_off, delta_off;
  logic [39:0]  heading_acc;

  function automatic int word16(int k);
    return int'($signed({frame_buf[k+1], frame_buf[k]}));
  endfunction

  // Step the yaw chain for one angle frame; return the corrected rate.
  function automatic longint yaw_step(int z);
    int     d;
    int unsigned n;
    longint rate_nb, delta_nb, corr, mag;
    corr = 0;
    d = z - prev_heading;
    if (d > 32768) d -= 65536;
    else if (d < -32768) d += 65536;
    prev_heading = z;
    if (stage == StWarm) begin
      if (stage_cnt + 1 >= warm_len) begin
        stage = StBias;
        stage_cnt = 0;
      end else begin
        stage_cnt++;
      end
    end else if (stage == StBias) begin
      n = stage_cnt + 1;
      bias_rate_acc += rate_latch;
      bias_delta_acc += d;
      if (n >= bias_len) begin
        rate_bias = (bias_rate_acc * 256) / longint'(n);
        delta_bias = (bias_delta_acc * 256) / longint'(n);
        bias_rate_acc = 0;
        bias_delta_acc = 0;
        stage_cnt = 0;
        stage = StRun;
      end else begin
        stage_cnt = n;
      end
    end else begin
      rate_nb = longint'(rate_latch) * 256 - rate_bias;
      delta_nb = longint'(d) * 256 - delta_bias;
      corr = rate_nb - rate_off;
      if (corr > imufp_pkg::CORR_MAX) corr = imufp_pkg::CORR_MAX;
      if (corr < imufp_pkg::CORR_MIN) corr = imufp_pkg::CORR_MIN;
      heading_acc = heading_acc + 40'(delta_nb - delta_off);
      mag = corr < 0 ? -corr : corr;
      if (mag < longint'(still_thr)) begin
        n = still_cnt + 1;
        still_rate_acc += rate_nb;
        still_delta_acc += delta_nb;
        if (n >= still_len) begin
          rate_off = still_rate_acc / longint'(n);
          delta_off = still_delta_acc / longint'(n);
          still_cnt = 0;
          still_rate_acc = 0;
          still_delta_acc = 0;
        end else begin
          still_cnt = n;
        end
      end else begin
        still_cnt = 0;
        still_rate_acc = 0;
        still_delta_acc = 0;
      end
    end
    return corr;
  endfunction

  function automatic void take_byte(logic [7:0] b);
    frame_result_t r;
    longint corr;
    case (phase)
      PhIdle: begin
        if (b == imufp_pkg::SYNC_BYTE) begin
          frame_buf[0] = b;
          phase = PhHead;
        end
      end
      PhHead: begin
        if (b >= imufp_pkg::TYPE_ACC && b <= imufp_pkg::TYPE_ANGLE) begin
          frame_buf[1] = b;
          sum8 = imufp_pkg::SYNC_BYTE + b;
          pos = 2;
          phase = PhBody;
        end else if (b != imufp_pkg::SYNC_BYTE) begin
          phase = PhIdle;
        end
      end
      default: begin
        if (pos < 10) begin
          frame_buf[pos] = b;
          sum8 = sum8 + b;
          pos++;
        end else begin
          phase = PhIdle;
          pos = 0;
          if (b == sum8) begin
            corr = 0;
            r.w = '0;
            if (frame_buf[1] == imufp_pkg::TYPE_ACC) begin
              r.kind = imufp_pkg::KIND_ACC;
              r.w = 16'(word16(8));
            end else if (frame_buf[1] == imufp_pkg::TYPE_RATE) begin
              r.kind = imufp_pkg::KIND_RATE;
              rate_latch = word16(6);
            end else begin
              r.kind = imufp_pkg::KIND_ANGLE;
              corr = yaw_step(word16(6));
            end
            r.x = 16'(word16(2));
            r.y = 16'(word16(4));
            r.z = 16'(word16(6));
            r.corr = imufp_pkg::CORR_W'(corr);
            r.yaw = heading_acc;
            r.ready = (stage == StRun);
            expected_frames.push_back(r);
          end
        end
      end
    endcase
  endfunction

  function automatic void report(string field, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    frame_result_t want;
    if (!rst_ni) begin
      warm_len = 100;
      bias_len = 200;
      still_len = 400;
      still_thr = 3355;
      phase = PhIdle;
      pos = 0;
      sum8 = '0;
      prev_heading = 0;
      rate_latch = 0;
      stage = StWarm;
      stage_cnt = 0;
      still_cnt = 0;
      bias_rate_acc = 0;
      bias_delta_acc = 0;
      rate_bias = 0;
      delta_bias = 0;
      still_rate_acc = 0;
      still_delta_acc = 0;
      rate_off = 0;
      delta_off = 0;
      heading_acc = '0;
      expected_frames.delete();
      fail_count_o = 0;
      checked_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          imufp_pkg::REG_WARMUP: warm_len = pwdata[9:0];
          imufp_pkg::REG_BIAS:   bias_len = pwdata[9:0];
          imufp_pkg::REG_STILL:  still_len = pwdata[9:0];
          imufp_pkg::REG_THRESH: still_thr = pwdata[23:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) take_byte(rx_byte_i);
      if (out_valid_i && out_ready_i) begin
        checked_o++;
        if (expected_frames.size() == 0) begin
          $display("%0t: result with nothing expected, kind %0d", $time, frame_kind_i);
          fail_count_o++;
        end else begin
          want = expected_frames.pop_front();
          report("frame_kind", want.kind, frame_kind_i);
          report("value_x", want.x, $unsigned(value_x_i));
          report("value_y", want.y, $unsigned(value_y_i));
          report("value_z", want.z, $unsigned(value_z_i));
          report("value_w", want.w, $unsigned(value_w_i));
          report("corrected_rate", want.corr, $unsigned(corrected_rate_i));
          report("yaw_total", want.yaw, $unsigned(yaw_total_i));
          report("yaw_ready", want.ready, yaw_ready_i);
        end
      end
    end
    pending_o = expected_frames.size();
  end

endmodule

// ===== bench/tb.sv =====
// Testbench top: drives bytes and register writes into the frame parser and gives the verdict.
`timescale 1ns / 1ps

module tb;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  frame_kind_o;
  logic signed [15:0] value_x_o, value_y_o, value_z_o, value_w_o;
  logic signed [imufp_pkg::CORR_W-1:0] corrected_rate_o;
  logic signed [39:0] yaw_total_o;
  logic        yaw_ready_o;
  int          fail_count, pending, checked;
  int          burst_left = 0, bytes_sent = 0, last_heading = 0;
  int          stall_mode = 0, stall_left = 0;

  imu_frame_parser_yaw_integrator u_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .rx_byte_i, .out_valid_o, .out_ready_i,
    .frame_kind_o, .value_x_o, .value_y_o, .value_z_o, .value_w_o,
    .corrected_rate_o, .yaw_total_o, .yaw_ready_o
  );

  yaw_frame_checker u_checker (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid_i, .in_ready_i(in_ready_o), .rx_byte_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .frame_kind_i(frame_kind_o), .value_x_i(value_x_o), .value_y_i(value_y_o),
    .value_z_i(value_z_o), .value_w_i(value_w_o), .corrected_rate_i(corrected_rate_o),
    .yaw_total_i(yaw_total_o), .yaw_ready_i(yaw_ready_o),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // Receiver: switch between always ready, random and mostly stalled.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= 1'($urandom_range(0, 1));
      default: out_ready_i <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic send_byte(logic [7:0] b);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? 200 : $urandom_range(1, 40);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_frame(logic [7:0] kind_byte, logic [15:0] x, logic [15:0] y,
                            logic [15:0] z, logic [15:0] w, bit corrupt);
    logic [7:0] body[10];
    logic [7:0] sum;
    body = '{imufp_pkg::SYNC_BYTE, kind_byte, x[7:0], x[15:8], y[7:0], y[15:8],
             z[7:0], z[15:8], w[7:0], w[15:8]};
    sum = '0;
    foreach (body[i]) begin
      sum += body[i];
      send_byte(body[i]);
    end
    if (corrupt) sum ^= 8'($urandom_range(1, 255));
    send_byte(sum);
  endtask

  // Drain the block, let any division finish, then write one register.
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic random_traffic(int n_bytes);
    int          sel, hz;
    logic [15:0] z;
    logic [7:0]  kb;
    while (bytes_sent < n_bytes) begin
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        send_byte(($urandom_range(0, 3) == 0) ? imufp_pkg::SYNC_BYTE : 8'($urandom));
      end else begin
        case ($urandom_range(0, 4))
          0:       kb = imufp_pkg::TYPE_ACC;
          1, 2:    kb = imufp_pkg::TYPE_RATE;
          default: kb = imufp_pkg::TYPE_ANGLE;
        endcase
        if (kb == imufp_pkg::TYPE_ANGLE) begin
          hz = ($urandom_range(0, 9) < 7) ? last_heading + $signed($urandom_range(0, 80)) - 40
                                          : $signed(16'($urandom));
          z = 16'(hz);
          last_heading = $signed(z);
        end else if (kb == imufp_pkg::TYPE_RATE && $urandom_range(0, 9) < 7) begin
          z = 16'($signed($urandom_range(0, 32)) - 16);
        end else begin
          z = 16'($urandom);
        end
        send_frame(kb, 16'($urandom), 16'($urandom), z, 16'($urandom), sel >= 92);
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(imufp_pkg::REG_WARMUP, 32'd2);
    write_reg(imufp_pkg::REG_BIAS, 32'd3);
    write_reg(imufp_pkg::REG_STILL, 32'd2);
    write_reg(imufp_pkg::REG_THRESH, 32'd3355);

    // Noise, bad type, double sync, extreme words, bad sum, heading wrap.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(imufp_pkg::SYNC_BYTE);
    send_byte(8'h54);
    send_byte(imufp_pkg::SYNC_BYTE);
    send_frame(imufp_pkg::TYPE_ACC, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h8000, 1'b0);
    send_frame(imufp_pkg::TYPE_RATE, 16'h7FFF, 16'h8000, 16'h0005, 16'h1234, 1'b0);
    send_frame(imufp_pkg::TYPE_ANGLE, 16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 1'b1);
    send_frame(imufp_pkg::TYPE_ANGLE, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h0000, 1'b0);
    send_frame(imufp_pkg::TYPE_ANGLE, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 1'b0);
    send_frame(imufp_pkg::TYPE_ANGLE, 16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 1'b0);
    send_frame(imufp_pkg::TYPE_ANGLE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    last_heading = 0;

    // Hold off until every result of the opening part is back.
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);

    random_traffic(400);
    write_reg(imufp_pkg::REG_STILL, 32'd1023);
    write_reg(imufp_pkg::REG_THRESH, 32'hFF_FFFF);
    random_traffic(700);
    write_reg(imufp_pkg::REG_STILL, 32'd0);
    write_reg(imufp_pkg::REG_THRESH, 32'd0);
    random_traffic(1000);
    write_reg(imufp_pkg::REG_WARMUP, 32'd1023);
    write_reg(imufp_pkg::REG_BIAS, 32'd1023);
    write_reg(imufp_pkg::REG_THRESH, 32'hFF_FFFF);
    random_traffic(1300);
    write_reg(imufp_pkg::REG_WARMUP, 32'd0);
    write_reg(imufp_pkg::REG_BIAS, 32'd0);
    write_reg(imufp_pkg::REG_STILL, 32'd4);
    write_reg(imufp_pkg::REG_THRESH, 32'd5000);
    random_traffic(1650);

    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Sent %0d bytes across five register settings; %0d frame results checked.",
             bytes_sent, checked);
    if (fail_count == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
